// ===== design/foks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foks_pkg
// Shared types, constants and helpers for the ordered-key FIFO.
// ----------------------------------------------------------------------------
package foks_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int PRICE_W = 32;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SRCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price_cents;
    } t_req_beat;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   out_key;
        logic [PRICE_W-1:0] out_price_cents;
        logic               now_empty;
        logic               now_full;
    } t_res_beat;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        return (s == IDX_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// ===== design/foks_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foks_core
// Record memory, head/tail pointers and the request sequencer.
// ----------------------------------------------------------------------------
module foks_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  foks_pkg::t_req_beat i_req,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output foks_pkg::t_res_beat o_res
);
    import foks_pkg::*;

    logic [KEY_W+PRICE_W-1:0] mem [DEPTH];
    logic [KEY_W+PRICE_W-1:0] r_rd_data;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_left, n_left;
    logic [KEY_W-1:0] r_key, n_key;
    t_res_beat        r_res, n_res;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_we;
    logic [IDX_W-1:0]         w_raddr;
    logic [KEY_W-1:0]         w_rd_key;
    logic                     w_greater;
    logic                     w_equal;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_rd_key    = r_rd_data[KEY_W-1:0];
    assign w_greater   = $signed(w_rd_key) > $signed(r_key);
    assign w_equal     = (w_rd_key == r_key);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_tail] <= {i_req.price_cents, i_req.key};
        end
        r_rd_data <= mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_DEQUEUE: n_state = w_empty ? ST_DONE : ST_DEQ;
                        REQ_SEARCH:  n_state = w_empty ? ST_DONE : ST_SRCH;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_DEQ: n_state = ST_DONE;
            ST_SRCH: begin
                if (w_greater || w_equal || r_left == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_slot  = r_slot;
        n_left  = r_left;
        n_key   = r_key;
        n_res   = r_res;
        w_we    = 1'b0;
        w_raddr = r_head;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_key = i_req.key;
                    n_res = '0;
                    case (i_req.req_type)
                        REQ_ENQUEUE: begin
                            if (!w_full) begin
                                w_we      = 1'b1;
                                n_tail    = next_slot(r_tail);
                                n_count   = r_count + 1'b1;
                                n_res.ok  = 1'b1;
                            end
                        end
                        REQ_SEARCH: begin
                            n_slot = r_head;
                            n_left = r_count - 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DEQ: begin
                n_res.ok      = 1'b1;
                n_res.out_key = w_rd_key;
                n_head        = next_slot(r_head);
                n_count       = r_count - 1'b1;
            end
            ST_SRCH: begin
                if (w_greater) begin
                    n_res.ok = 1'b0;
                end else if (w_equal) begin
                    n_res.ok              = 1'b1;
                    n_res.out_price_cents = r_rd_data[KEY_W+PRICE_W-1:KEY_W];
                end else if (r_left != '0) begin
                    n_slot  = next_slot(r_slot);
                    w_raddr = next_slot(r_slot);
                    n_left  = r_left - 1'b1;
                end
            end
            default: ;
        endcase
        if (r_state != ST_DONE) begin
            n_res.now_empty = (n_count == '0);
            n_res.now_full  = (n_count == CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_left <= n_left;
        r_key  <= n_key;
        r_res  <= n_res;
    end

endmodule

// ===== design/fifo_with_ordered_key_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_ordered_key_search_top
// Bounded FIFO of key and price records with a search from the head.
// ----------------------------------------------------------------------------
// The slave channel takes one request per beat: s_axis_tuser holds the
// request kind (enqueue, dequeue, search) and s_axis_tdata holds key and
// price. The master channel returns exactly one result beat per request.
// Records live in one memory with a registered read port. An enqueue, an
// unused code or a request that finds the queue empty or full passes
// straight to the result state; a dequeue first reads the head record, and
// a search reads stored records one per cycle from the head. One request
// is in work at a time: the next one is taken the cycle after the core
// hands its result on.
// The output register holds a finished result until the receiver takes it,
// and the next request is accepted meanwhile; a result that finishes while
// the register is still full waits inside the core and stalls the input.
// A synchronous reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module fifo_with_ordered_key_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // key[31:0], price_cents[63:32]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // ok[0], out_key[32:1],
                                       // out_price_cents[64:33], now_empty[65],
                                       // now_full[66], zero[71:67]
);
    import foks_pkg::*;

    t_req_beat w_req;
    t_res_beat w_res;
    logic      w_res_valid;
    logic      w_res_ready;
    logic      r_out_valid;
    t_res_beat r_out;

    assign w_req.req_type    = s_axis_tuser;
    assign w_req.key         = s_axis_tdata[31:0];
    assign w_req.price_cents = s_axis_tdata[63:32];

    foks_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.now_full, r_out.now_empty,
                            r_out.out_price_cents, r_out.out_key, r_out.ok};

    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res_ready |=> r_out_valid)
        else $error("core result lost at the output register");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.now_empty && r_out.now_full))
        else $error("queue reported empty and full at once");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

endmodule
